// ===== hdl/mlbpe_pkg.sv =====
// shared types and constants for the multi-lamp blink pattern engine
// no dependencies; used by the top level module by scoped names

package mlbpe_pkg;

    // item kinds carried on the input tuser
    typedef enum logic [2:0] {
        ACT_TICK          = 3'd0,
        ACT_ON_FOR        = 3'd1,
        ACT_OFF_FOR       = 3'd2,
        ACT_BLINK         = 3'd3,
        ACT_WORD_LOAD     = 3'd4,
        ACT_PATTERN_START = 3'd5
    } action_t;

    // per-lamp operating mode
    typedef enum logic [2:0] {
        MODE_ON         = 3'd0,
        MODE_OFF        = 3'd1,
        MODE_BLINK_LIT  = 3'd2,
        MODE_BLINK_DARK = 3'd3,
        MODE_PATTERN    = 3'd4
    } mode_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VISIT,
        ST_VISIT_LOAD,
        ST_CMD,
        ST_CMD_LOAD,
        ST_RESULT
    } state_t;

    localparam logic [7:0] FOREVER           = 8'd255;
    localparam logic [7:0] MIN_PATTERN_STEPS = 8'd2;

    // field widths
    localparam int ACTION_W   = 3;
    localparam int LED_W      = 3;
    localparam int DURATION_W = 32;
    localparam int COUNT_W    = 8;
    localparam int LENGTH_W   = 8;
    localparam int INDEX_W    = 4;
    localparam int VALUE_W    = 16;
    localparam int MASK_W     = 5;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 16;

endpackage

// ===== hdl/mlbpe_step_ram.sv =====
// pattern step store: one write port, one read port with registered read data
// depends on nothing; contents are undefined until written

module mlbpe_step_ram #(
    parameter int DEPTH = 80,
    parameter int AW    = 7,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/multi_led_blink_pattern_engine.sv =====
// top level of the multi-lamp blink pattern engine: sequencer, lamp state, result register
// depends on mlbpe_pkg and mlbpe_step_ram
//
//  channel | dir | payload                                         | sideband
//  --------+-----+-------------------------------------------------+-------------------
//  s_*     | in  | led, duration, repeat_count, pattern_length,    | tuser: action
//          |     | entry_index, entry_value                        |
//  m_*     | out | lit_mask, timer_mask                            | none
//
//  a tick visits the lamps one per cycle through one shared countdown/compare unit,
//  except that a lamp whose pattern step expires also waits in ST_VISIT_LOAD for the
//  step store read. a tick ends in ST_RESULT; a command passes through ST_CMD, a pattern
//  start also through ST_CMD_LOAD, before ST_RESULT; an ignored item goes to ST_RESULT.
//  the next transfer can be taken in the cycle the result shows, if m_tready is high.
//  one item at a time: s_tready is low from the transfer until the result is loaded.
//  the result register frees the input side once loaded; a stalled m_tready holds
//  the next input back only until that result is taken.
//  reset clears all lamp state; the step store is not cleared.

module multi_led_blink_pattern_engine #(
    parameter int LEDS        = 5,
    parameter int PATTERN_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] led, [34:3] duration, [42:35] repeat_count, [50:43] pattern_length,
    // [54:51] entry_index, [70:55] entry_value, [71] zero
    input  logic [71:0] s_tdata,
    // [2:0] action
    input  logic [2:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] lit_mask, [9:5] timer_mask, [15:10] zero
    output logic [15:0] m_tdata
);

    localparam int IW    = (LEDS > 1) ? $clog2(LEDS) : 1;
    localparam int PW    = $clog2(PATTERN_LEN);
    localparam int UW    = $clog2(PATTERN_LEN + 1);
    localparam int DEPTH = LEDS * PATTERN_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = mlbpe_pkg::VALUE_W;

    // input field unpacking
    logic [2:0]  in_led;
    logic [31:0] in_duration;
    logic [7:0]  in_count;
    logic [7:0]  in_length;
    logic [3:0]  in_index;
    logic [15:0] in_value;
    mlbpe_pkg::action_t in_action;

    assign in_led      = s_tdata[2:0];
    assign in_duration = s_tdata[34:3];
    assign in_count    = s_tdata[42:35];
    assign in_length   = s_tdata[50:43];
    assign in_index    = s_tdata[54:51];
    assign in_value    = s_tdata[70:55];
    assign in_action   = mlbpe_pkg::action_t'(s_tuser);

    // latched item
    mlbpe_pkg::action_t act_reg;
    logic [31:0] dur_reg;
    logic [7:0]  cnt_reg;
    logic [7:0]  len_reg;
    logic [3:0]  idx_reg;
    logic [15:0] val_reg;

    // sequencer
    mlbpe_pkg::state_t state_reg, state_next;
    logic [IW-1:0] cur_reg, cur_next;

    // per-lamp state
    logic               lit_reg  [LEDS];
    mlbpe_pkg::mode_t   mode_reg [LEDS];
    logic [31:0]        rem_reg  [LEDS];
    logic               pend_reg [LEDS];
    logic [7:0]         rep_reg  [LEDS];
    logic [15:0]        half_reg [LEDS];
    logic [UW-1:0]      used_reg [LEDS];
    logic [PW-1:0]      pos_reg  [LEDS];

    // result register
    logic                        m_valid_reg;
    logic [mlbpe_pkg::MASK_W-1:0] lit_mask_reg;
    logic [mlbpe_pkg::MASK_W-1:0] timer_mask_reg;

    logic s_accept;
    logic cmd_ok;
    logic start_ok;
    logic slot_ok;
    logic last_lamp;
    logic need_load;

    // current lamp view
    logic             cur_lit;
    mlbpe_pkg::mode_t cur_mode;
    logic [31:0]      cur_rem;
    logic             cur_pend;
    logic [7:0]       cur_rep;
    logic [15:0]      cur_half;
    logic [UW-1:0]    cur_used;
    logic [PW-1:0]    cur_pos;

    // lamp update
    logic             lamp_we;
    logic             lit_next;
    mlbpe_pkg::mode_t mode_next;
    logic [31:0]      rem_next;
    logic             pend_next;
    logic [7:0]       rep_next;
    logic [15:0]      half_next;
    logic [UW-1:0]    used_next;
    logic [PW-1:0]    pos_next;
    logic [UW-1:0]    pos_inc;
    logic             pos_wrap;

    // step store port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic [AW-1:0] base_addr;

    logic [mlbpe_pkg::MASK_W-1:0] lit_vec;
    logic [mlbpe_pkg::MASK_W-1:0] pend_vec;

    assign s_tready = (state_reg == mlbpe_pkg::ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    // a command is only worked on for a real lamp and a known action
    assign cmd_ok = (4'(in_led) < 4'(LEDS))
                 && (in_action inside {mlbpe_pkg::ACT_ON_FOR, mlbpe_pkg::ACT_OFF_FOR,
                                       mlbpe_pkg::ACT_BLINK, mlbpe_pkg::ACT_WORD_LOAD,
                                       mlbpe_pkg::ACT_PATTERN_START});

    assign start_ok  = (act_reg == mlbpe_pkg::ACT_PATTERN_START)
                    && (len_reg >= mlbpe_pkg::MIN_PATTERN_STEPS);
    assign slot_ok   = (8'(idx_reg) < 8'(PATTERN_LEN));
    assign last_lamp = (cur_reg == IW'(LEDS - 1));

    assign cur_lit  = lit_reg[cur_reg];
    assign cur_mode = mode_reg[cur_reg];
    assign cur_rem  = rem_reg[cur_reg];
    assign cur_pend = pend_reg[cur_reg];
    assign cur_rep  = rep_reg[cur_reg];
    assign cur_half = half_reg[cur_reg];
    assign cur_used = used_reg[cur_reg];
    assign cur_pos  = pos_reg[cur_reg];

    // shared countdown compare: expiry of a pattern lamp with passes left needs a store read
    assign need_load = cur_pend && (cur_rem <= 32'd1)
                    && (cur_mode == mlbpe_pkg::MODE_PATTERN) && (cur_rep != 8'd0);

    assign base_addr = AW'(cur_reg) * AW'(PATTERN_LEN);
    assign pos_inc   = UW'(cur_pos) + UW'(1);
    assign pos_wrap  = (pos_inc >= cur_used);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mlbpe_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (in_action == mlbpe_pkg::ACT_TICK)
                    begin
                        state_next = mlbpe_pkg::ST_VISIT;
                    end
                    else if (cmd_ok)
                    begin
                        state_next = mlbpe_pkg::ST_CMD;
                    end
                    else
                    begin
                        state_next = mlbpe_pkg::ST_RESULT;
                    end
                end
            end
            mlbpe_pkg::ST_VISIT:
            begin
                if (need_load)
                begin
                    state_next = mlbpe_pkg::ST_VISIT_LOAD;
                end
                else if (last_lamp)
                begin
                    state_next = mlbpe_pkg::ST_RESULT;
                end
            end
            mlbpe_pkg::ST_VISIT_LOAD:
            begin
                state_next = last_lamp ? mlbpe_pkg::ST_RESULT : mlbpe_pkg::ST_VISIT;
            end
            mlbpe_pkg::ST_CMD:
            begin
                state_next = start_ok ? mlbpe_pkg::ST_CMD_LOAD : mlbpe_pkg::ST_RESULT;
            end
            mlbpe_pkg::ST_CMD_LOAD:
            begin
                state_next = mlbpe_pkg::ST_RESULT;
            end
            mlbpe_pkg::ST_RESULT:
            begin
                state_next = mlbpe_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mlbpe_pkg::ST_IDLE;
            end
        endcase
    end

    // lamp index walk
    always_comb
    begin
        cur_next = cur_reg;
        unique case (state_reg)
            mlbpe_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    cur_next = (in_action == mlbpe_pkg::ACT_TICK) ? '0 : IW'(in_led);
                end
            end
            mlbpe_pkg::ST_VISIT:
            begin
                if (!need_load && !last_lamp)
                begin
                    cur_next = cur_reg + IW'(1);
                end
            end
            mlbpe_pkg::ST_VISIT_LOAD:
            begin
                if (!last_lamp)
                begin
                    cur_next = cur_reg + IW'(1);
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    // lamp update and store access for the lamp under the sequencer
    always_comb
    begin
        lamp_we   = 1'b0;
        lit_next  = cur_lit;
        mode_next = cur_mode;
        rem_next  = cur_rem;
        pend_next = cur_pend;
        rep_next  = cur_rep;
        half_next = cur_half;
        used_next = cur_used;
        pos_next  = cur_pos;
        rd_addr   = base_addr + AW'(cur_pos);
        wr_en     = 1'b0;
        wr_addr   = base_addr + AW'(idx_reg);
        wr_data   = val_reg;
        unique case (state_reg)
            mlbpe_pkg::ST_VISIT:
            begin
                if (cur_pend)
                begin
                    lamp_we = 1'b1;
                    if (cur_rem > 32'd1)
                    begin
                        rem_next = cur_rem - 32'd1;
                    end
                    else
                    begin
                        rem_next = '0;
                        case (cur_mode)
                            mlbpe_pkg::MODE_ON:
                            begin
                                lit_next  = 1'b0;
                                pend_next = 1'b0;
                            end
                            mlbpe_pkg::MODE_OFF:
                            begin
                                lit_next  = 1'b1;
                                pend_next = 1'b0;
                            end
                            mlbpe_pkg::MODE_BLINK_LIT:
                            begin
                                lit_next = 1'b0;
                                // count of zero or all ones keeps blinking
                                if ((cur_rep == 8'd0) || (cur_rep == mlbpe_pkg::FOREVER))
                                begin
                                    mode_next = mlbpe_pkg::MODE_BLINK_DARK;
                                    rem_next  = 32'(cur_half);
                                end
                                else
                                begin
                                    rep_next = cur_rep - 8'd1;
                                    if (cur_rep != 8'd1)
                                    begin
                                        mode_next = mlbpe_pkg::MODE_BLINK_DARK;
                                        rem_next  = 32'(cur_half);
                                    end
                                    else
                                    begin
                                        mode_next = mlbpe_pkg::MODE_OFF;
                                        pend_next = 1'b0;
                                    end
                                end
                            end
                            mlbpe_pkg::MODE_BLINK_DARK:
                            begin
                                lit_next  = 1'b1;
                                mode_next = mlbpe_pkg::MODE_BLINK_LIT;
                                rem_next  = 32'(cur_half);
                            end
                            mlbpe_pkg::MODE_PATTERN:
                            begin
                                // passes left: step reload follows after the store read
                                if (cur_rep == 8'd0)
                                begin
                                    lit_next  = 1'b0;
                                    mode_next = mlbpe_pkg::MODE_OFF;
                                    pend_next = 1'b0;
                                end
                            end
                            default:
                            begin
                                pend_next = 1'b0;
                            end
                        endcase
                    end
                end
            end
            mlbpe_pkg::ST_VISIT_LOAD:
            begin
                // even steps lit, odd steps dark
                lamp_we   = 1'b1;
                lit_next  = ~cur_pos[0];
                rem_next  = 32'(rd_data);
                pend_next = 1'b1;
                if (pos_wrap)
                begin
                    pos_next = '0;
                    if (cur_rep != mlbpe_pkg::FOREVER)
                    begin
                        rep_next = cur_rep - 8'd1;
                    end
                end
                else
                begin
                    pos_next = PW'(pos_inc);
                end
            end
            mlbpe_pkg::ST_CMD:
            begin
                case (act_reg)
                    mlbpe_pkg::ACT_ON_FOR, mlbpe_pkg::ACT_OFF_FOR:
                    begin
                        lamp_we   = 1'b1;
                        lit_next  = (act_reg == mlbpe_pkg::ACT_ON_FOR);
                        mode_next = (act_reg == mlbpe_pkg::ACT_ON_FOR) ?
                                    mlbpe_pkg::MODE_ON : mlbpe_pkg::MODE_OFF;
                        rem_next  = dur_reg;
                        pend_next = (dur_reg != 32'd0);
                    end
                    mlbpe_pkg::ACT_BLINK:
                    begin
                        lamp_we   = 1'b1;
                        half_next = dur_reg[15:0];
                        lit_next  = 1'b0;
                        mode_next = mlbpe_pkg::MODE_BLINK_DARK;
                        rem_next  = 32'(dur_reg[15:0]);
                        pend_next = 1'b1;
                        rep_next  = cnt_reg;
                    end
                    mlbpe_pkg::ACT_WORD_LOAD:
                    begin
                        wr_en = slot_ok;
                    end
                    mlbpe_pkg::ACT_PATTERN_START:
                    begin
                        rd_addr = base_addr;
                        if (start_ok)
                        begin
                            lamp_we   = 1'b1;
                            lit_next  = 1'b1;
                            mode_next = mlbpe_pkg::MODE_PATTERN;
                            used_next = (len_reg > 8'(PATTERN_LEN)) ?
                                        UW'(PATTERN_LEN) : UW'(len_reg);
                            rep_next  = cnt_reg;
                            pos_next  = PW'(1);
                        end
                    end
                    default:
                    begin
                        lamp_we = 1'b0;
                    end
                endcase
            end
            mlbpe_pkg::ST_CMD_LOAD:
            begin
                // arm with the first pattern step
                lamp_we   = 1'b1;
                rem_next  = 32'(rd_data);
                pend_next = 1'b1;
            end
            default:
            begin
                lamp_we = 1'b0;
            end
        endcase
    end

    // result masks: lamps beyond the fifth are not reported
    always_comb
    begin
        lit_vec  = '0;
        pend_vec = '0;
        for (int k = 0; k < mlbpe_pkg::MASK_W; k++)
        begin
            if (k < LEDS)
            begin
                lit_vec[k]  = lit_reg[k];
                pend_vec[k] = pend_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlbpe_pkg::ST_IDLE;
            cur_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
        end
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            act_reg <= in_action;
            dur_reg <= in_duration;
            cnt_reg <= in_count;
            len_reg <= in_length;
            idx_reg <= in_index;
            val_reg <= in_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LEDS; k++)
            begin
                lit_reg[k]  <= 1'b0;
                mode_reg[k] <= mlbpe_pkg::MODE_OFF;
                rem_reg[k]  <= '0;
                pend_reg[k] <= 1'b0;
                rep_reg[k]  <= '0;
                half_reg[k] <= '0;
                used_reg[k] <= '0;
                pos_reg[k]  <= '0;
            end
        end
        else if (lamp_we)
        begin
            lit_reg[cur_reg]  <= lit_next;
            mode_reg[cur_reg] <= mode_next;
            rem_reg[cur_reg]  <= rem_next;
            pend_reg[cur_reg] <= pend_next;
            rep_reg[cur_reg]  <= rep_next;
            half_reg[cur_reg] <= half_next;
            used_reg[cur_reg] <= used_next;
            pos_reg[cur_reg]  <= pos_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (state_reg == mlbpe_pkg::ST_RESULT)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mlbpe_pkg::ST_RESULT)
        begin
            lit_mask_reg   <= lit_vec;
            timer_mask_reg <= pend_vec;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, timer_mask_reg, lit_mask_reg};

    mlbpe_step_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_step_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ===== hdl/mlbpe_checker.sv =====
// port-level checks for the multi-lamp blink pattern engine
// depends on nothing; attached to the top level by the bind below

module mlbpe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // one item at a time
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after a transfer");

    // a result never shows in the cycle after an input transfer
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result appeared before the item was worked on");

    // a new result only follows a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:10] == 6'd0))
        else $error("result padding not zero");

endmodule

bind multi_led_blink_pattern_engine mlbpe_checker u_mlbpe_checker (.*);
